### design/bbjt_pkg.sv
// Package for the bounding box join table: sizes, payload types and state codes.
`timescale 1ns / 1ps

package bbjt_pkg;

  localparam int TABLE_DEPTH     = 16;
  localparam int COORD_BITS      = 12;
  localparam int SIZE_BITS       = COORD_BITS + 1;
  localparam int STORE_SIZE_BITS = COORD_BITS + 2;
  localparam int EDGE_BITS       = COORD_BITS + 3;
  localparam int DIFF_BITS       = COORD_BITS + 4;
  localparam int GAP_BITS        = 13;
  localparam int INDEX_OUT_BITS  = 4;
  localparam int IDX_BITS        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_BITS      = $clog2(TABLE_DEPTH + 1);

  localparam logic signed [GAP_BITS-1:0] GAP_RESET = GAP_BITS'(10);

  typedef enum logic [1:0] {
    KIND_JOINED   = 2'd0,
    KIND_APPENDED = 2'd1,
    KIND_DROPPED  = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_APPEND,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                  start_new_set;
    logic [COORD_BITS-1:0] rect_x;
    logic [COORD_BITS-1:0] rect_y;
    logic [SIZE_BITS-1:0]  rect_width;
    logic [SIZE_BITS-1:0]  rect_height;
  } rect_in_t;

  typedef struct packed {
    result_kind_e              result_kind;
    logic [INDEX_OUT_BITS-1:0] entry_index;
    logic [COORD_BITS-1:0]     out_x;
    logic [COORD_BITS-1:0]     out_y;
    logic [SIZE_BITS-1:0]      out_width;
    logic [SIZE_BITS-1:0]      out_height;
  } rect_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]      x;
    logic [COORD_BITS-1:0]      y;
    logic [STORE_SIZE_BITS-1:0] w;
    logic [STORE_SIZE_BITS-1:0] h;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    logic   match;
    entry_t merged;
  } join_result_t;

endpackage

### design/bbjt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bbjt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/bbjt_join_unit.sv
// Join test and union of the new rectangle with one stored entry.
`timescale 1ns / 1ps

module bbjt_join_unit (
  input  bbjt_pkg::entry_t                         new_i,
  input  bbjt_pkg::entry_t                         stored_i,
  input  logic signed [bbjt_pkg::GAP_BITS-1:0]     gap_i,
  output bbjt_pkg::join_result_t                   result_o
);
  import bbjt_pkg::*;

  entry_t                       lft, rgt, top, bot;
  logic signed [DIFF_BITS-1:0]  h_gap, gap_ext;
  logic [EDGE_BITS-1:0]         top_edge, lft_right, rgt_right, lft_bottom, rgt_bottom;
  logic [EDGE_BITS-1:0]         max_right, max_bottom;
  logic [COORD_BITS-1:0]        min_x, min_y;
  logic                         h_ok, v_ok, lft_empty, rgt_empty;
  entry_t                       span;

  always_comb begin
    if (stored_i.x < new_i.x) begin
      lft = stored_i;
      rgt = new_i;
    end else begin
      lft = new_i;
      rgt = stored_i;
    end

    gap_ext = DIFF_BITS'(gap_i);
    h_gap   = $signed(DIFF_BITS'(rgt.x)) - $signed(DIFF_BITS'(lft.x))
              - $signed(DIFF_BITS'(lft.w));
    h_ok    = h_gap < gap_ext;

    if (lft.y < rgt.y) begin
      top = lft;
      bot = rgt;
    end else begin
      top = rgt;
      bot = lft;
    end
    top_edge = EDGE_BITS'(top.y) + EDGE_BITS'(top.h);
    v_ok     = EDGE_BITS'(bot.y) <= top_edge;

    lft_empty  = (lft.w == '0) || (lft.h == '0);
    rgt_empty  = (rgt.w == '0) || (rgt.h == '0);
    min_x      = (lft.x < rgt.x) ? lft.x : rgt.x;
    min_y      = (lft.y < rgt.y) ? lft.y : rgt.y;
    lft_right  = EDGE_BITS'(lft.x) + EDGE_BITS'(lft.w);
    rgt_right  = EDGE_BITS'(rgt.x) + EDGE_BITS'(rgt.w);
    lft_bottom = EDGE_BITS'(lft.y) + EDGE_BITS'(lft.h);
    rgt_bottom = EDGE_BITS'(rgt.y) + EDGE_BITS'(rgt.h);
    max_right  = (lft_right > rgt_right) ? lft_right : rgt_right;
    max_bottom = (lft_bottom > rgt_bottom) ? lft_bottom : rgt_bottom;

    span.x = min_x;
    span.y = min_y;
    span.w = STORE_SIZE_BITS'(max_right - EDGE_BITS'(min_x));
    span.h = STORE_SIZE_BITS'(max_bottom - EDGE_BITS'(min_y));

    result_o.match = h_ok && v_ok;
    if (lft_empty) begin
      result_o.merged = rgt;
    end else if (rgt_empty) begin
      result_o.merged = lft;
    end else begin
      result_o.merged = span;
    end
  end

endmodule

### design/bounding_box_join_table.sv
// Top level of the bounding box join table: sequencer, table memory and result register.
// With no join, a rectangle passes from ST_IDLE through ST_TEST for each stored entry
// scanned, then ST_APPEND and ST_EMIT, into the result register. The scan walks the
// table one entry per cycle through the shared join test unit and the single read port
// of the table memory. The input is stalled while busy.
// Reset clears the entry count, the state and the result valid flag and sets the join gap
// to 10; table contents stay undefined until written.
`timescale 1ns / 1ps

module bounding_box_join_table (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  bbjt_pkg::rect_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output bbjt_pkg::rect_out_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic signed [bbjt_pkg::GAP_BITS-1:0]  cfg_wdata_i
);
  import bbjt_pkg::*;

  state_e                       state_q, state_d;
  logic signed [GAP_BITS-1:0]   gap_q;
  logic [COUNT_BITS-1:0]        count_q, count_d;
  logic [IDX_BITS-1:0]          idx_q, idx_d;
  entry_t                       new_q, new_d;
  entry_t                       res_q, res_d;
  result_kind_e                 kind_q, kind_d;
  logic [IDX_BITS-1:0]          res_idx_q, res_idx_d;
  logic                         out_valid_q, out_valid_d;
  rect_out_t                    out_q, out_d;

  logic                         in_xfer, out_free, last_entry;
  logic                         ram_we;
  logic [IDX_BITS-1:0]          ram_waddr;
  entry_t                       ram_wdata, ram_rdata;
  join_result_t                 join_res;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_entry  = (COUNT_BITS'(idx_q) + COUNT_BITS'(1)) == count_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  bbjt_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(idx_d),
    .rdata_o(ram_rdata)
  );

  bbjt_join_unit u_join (
    .new_i   (new_q),
    .stored_i(ram_rdata),
    .gap_i   (gap_q),
    .result_o(join_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.start_new_set || (count_q == '0)) begin
            state_d = ST_APPEND;
          end else begin
            state_d = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        if (join_res.match) begin
          state_d = ST_EMIT;
        end else if (last_entry) begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    new_d       = new_q;
    res_d       = res_q;
    kind_d      = kind_q;
    res_idx_d   = res_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = new_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_d   = '0;
          new_d.x = in_data_i.rect_x;
          new_d.y = in_data_i.rect_y;
          new_d.w = STORE_SIZE_BITS'(in_data_i.rect_width);
          new_d.h = STORE_SIZE_BITS'(in_data_i.rect_height);
          if (in_data_i.start_new_set) begin
            count_d = '0;
          end
        end
      end
      ST_TEST: begin
        if (join_res.match) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = join_res.merged;
          res_d     = join_res.merged;
          kind_d    = KIND_JOINED;
          res_idx_d = idx_q;
        end else if (!last_entry) begin
          idx_d = idx_q + IDX_BITS'(1);
        end
      end
      ST_APPEND: begin
        res_d = new_q;
        if (count_q < COUNT_BITS'(TABLE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_BITS'(count_q);
          ram_wdata = new_q;
          kind_d    = KIND_APPENDED;
          res_idx_d = IDX_BITS'(count_q);
          count_d   = count_q + COUNT_BITS'(1);
        end else begin
          kind_d    = KIND_DROPPED;
          res_idx_d = '0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.result_kind      = kind_q;
          out_d.entry_index      = INDEX_OUT_BITS'(res_idx_q);
          out_d.out_x            = res_q.x;
          out_d.out_y            = res_q.y;
          out_d.out_width        = SIZE_BITS'(res_q.w);
          out_d.out_height       = SIZE_BITS'(res_q.h);
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      gap_q       <= GAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_q     <= new_d;
    res_q     <= res_d;
    kind_q    <= kind_d;
    res_idx_q <= res_idx_d;
    out_q     <= out_d;
  end

endmodule
